### rtl/bled_pkg.sv
package bled_pkg;

    typedef struct packed {
        logic button_one_level;
        logic button_two_level;
    } t_in_item;

    typedef struct packed {
        logic       led_one;
        logic       led_two;
        logic [1:0] pattern;
        logic       running;
    } t_out_item;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 3;

    localparam logic [COUNT_W-1:0] WAIT_RESET = 16'd500;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

    localparam logic REG_WAIT_TICKS = 1'b0;

    localparam logic [1:0] PAT_BLINK_ONE  = 2'd0;
    localparam logic [1:0] PAT_BLINK_TWO  = 2'd1;
    localparam logic [1:0] PAT_BLINK_BOTH = 2'd2;
    localparam logic [1:0] PAT_ALTERNATE  = 2'd3;

endpackage

### rtl/bled_regs.sv
module bled_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bled_pkg::ADDR_W-1:0]    paddr,
    input  logic [bled_pkg::DATA_W-1:0]    pwdata,
    output logic [bled_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output logic [bled_pkg::COUNT_W-1:0]   o_wait_ticks
);
    import bled_pkg::*;

    logic [COUNT_W-1:0] r_wait_ticks;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_WAIT_TICKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= WAIT_RESET;
        end else if (wr_en) begin
            r_wait_ticks <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_WAIT_TICKS) begin
            prdata = {{(DATA_W-COUNT_W){1'b0}}, r_wait_ticks};
        end
    end

    assign o_wait_ticks = r_wait_ticks;

endmodule

### rtl/bled_core.sv
module bled_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  bled_pkg::t_in_item             i_item,
    input  logic [bled_pkg::COUNT_W-1:0]   i_wait_ticks,
    output bled_pkg::t_out_item            o_result
);
    import bled_pkg::*;

    logic [COUNT_W-1:0] r_period;
    logic [COUNT_W-1:0] r_debounce;
    logic [1:0]         r_pattern;
    logic               r_active;
    logic               r_first_armed;
    logic               r_second_armed;
    logic               r_phase;
    logic               r_led_one;
    logic               r_led_two;

    logic [COUNT_W-1:0] n_period;
    logic [COUNT_W-1:0] n_debounce;
    logic [1:0]         n_pattern;
    logic               n_active;
    logic               n_first_armed;
    logic               n_second_armed;
    logic               n_phase;
    logic               n_led_one;
    logic               n_led_two;

    logic [COUNT_W-1:0] half;
    logic               press_one;
    logic               press_two;

    assign half      = i_wait_ticks >> 1;
    assign press_one = !i_item.button_one_level;
    assign press_two = !i_item.button_two_level;

    always_comb begin
        n_period       = (r_period == COUNT_MAX) ? COUNT_MAX : r_period + 16'd1;
        n_debounce     = (r_debounce == COUNT_MAX) ? COUNT_MAX : r_debounce + 16'd1;
        n_pattern      = r_pattern;
        n_active       = r_active;
        n_first_armed  = r_first_armed;
        n_second_armed = r_second_armed;
        n_phase        = r_phase;
        n_led_one      = r_led_one;
        n_led_two      = r_led_two;

        if (press_one && !n_first_armed) begin
            n_first_armed = 1'b1;
            n_debounce    = '0;
        end
        if (press_one && n_first_armed && (n_debounce >= half) && !n_active) begin
            n_pattern     = n_pattern + 2'd1;
            n_first_armed = 1'b0;
        end

        if (press_two && !n_second_armed) begin
            n_second_armed = 1'b1;
            n_debounce     = '0;
        end
        if (press_two && n_second_armed && (n_debounce >= half)) begin
            n_led_one = 1'b0;
            n_led_two = 1'b0;
            n_period  = '0;
            if (n_active) begin
                n_pattern = PAT_BLINK_ONE;
            end
            n_active       = !n_active;
            n_second_armed = 1'b0;
        end

        if ((n_period == i_wait_ticks) && n_active) begin
            case (n_pattern)
                PAT_BLINK_ONE: begin
                    n_led_one = !n_led_one;
                    n_led_two = 1'b0;
                end
                PAT_BLINK_TWO: begin
                    n_led_one = 1'b0;
                    n_led_two = !n_led_two;
                end
                PAT_BLINK_BOTH: begin
                    n_led_one = r_phase;
                    n_led_two = r_phase;
                    n_phase   = !r_phase;
                end
                default: begin
                    n_led_one = r_phase;
                    n_led_two = !r_phase;
                    n_phase   = !r_phase;
                end
            endcase
            n_period = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period       <= '0;
            r_debounce     <= '0;
            r_pattern      <= PAT_BLINK_ONE;
            r_active       <= 1'b0;
            r_first_armed  <= 1'b0;
            r_second_armed <= 1'b0;
            r_phase        <= 1'b1;
            r_led_one      <= 1'b1;
            r_led_two      <= 1'b1;
        end else if (i_advance) begin
            r_period       <= n_period;
            r_debounce     <= n_debounce;
            r_pattern      <= n_pattern;
            r_active       <= n_active;
            r_first_armed  <= n_first_armed;
            r_second_armed <= n_second_armed;
            r_phase        <= n_phase;
            r_led_one      <= n_led_one;
            r_led_two      <= n_led_two;
        end
    end

    assign o_result.led_one = n_led_one;
    assign o_result.led_two = n_led_two;
    assign o_result.pattern = n_pattern;
    assign o_result.running = n_active;

    // The pattern cannot change while the block stays active.
    a_pattern_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_active && n_active) |=> $stable(r_pattern))
        else $error("pattern changed while active");

    // The LEDs hold while the block stays inactive.
    a_leds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !r_active && !n_active) |=> ($stable(r_led_one) && $stable(r_led_two)))
        else $error("LED changed while inactive");

    // Leaving the active state always clears the pattern and both LEDs.
    a_deactivate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_active && !n_active)
        |=> (r_pattern == PAT_BLINK_ONE && !r_led_one && !r_led_two))
        else $error("deactivation left pattern or LEDs set");

endmodule

### rtl/button_led_pattern_controller.sv
// A request accepted into the input register moves into the output register at the
// first edge at which the output is not stalled; each stalling edge holds it there.
// Throughput: one request per cycle unless the output stalls; the whole tick update is
// one combinational pass from the input register into the state and result registers.
// Reset is synchronous and active low: state returns to its power-on values,
// wait_ticks to 500, and both request stages empty.
module button_led_pattern_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bled_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bled_pkg::t_out_item            o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bled_pkg::ADDR_W-1:0]    paddr,
    input  logic [bled_pkg::DATA_W-1:0]    pwdata,
    output logic [bled_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import bled_pkg::*;

    logic [COUNT_W-1:0] wait_ticks;
    logic               r_in_valid;
    t_in_item           r_in_data;
    logic               r_out_valid;
    t_out_item          r_out_data;
    t_out_item          result;
    logic               out_load;
    logic               advance;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;

    bled_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_wait_ticks (wait_ticks)
    );

    bled_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (r_in_data),
        .i_wait_ticks (wait_ticks),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A request waiting in the input stage is kept until the output takes it.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_load) |=> (r_in_valid && $stable(r_in_data)))
        else $error("input request lost while output stalled");

    // A request that leaves the input stage always appears at the output.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced request missing at output");

    // The input side only stalls when the input stage is occupied.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without cause");

endmodule
